/* hdl/cpqs_pkg.sv */
// Shared types and constants for the circular priority queue.
package cpqs_pkg;

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int CAP_W    = 5;
   localparam int STATUS_W = 2;

   // Operation codes carried by a request word.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Status codes carried by a response word.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // One stored entry of the queue.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;     // take a new entry this cycle
      logic take_wrap; // take the entry leaving cell zero instead of the neighbour's
      logic load;      // write the incoming request entry
   } cell_ctl_type;

endpackage

/* hdl/cpqs_cell.sv */
// One storage cell of the queue chain.
module cpqs_cell (
   input  logic                    clock,
   input  cpqs_pkg::cell_ctl_type  ctl,
   input  cpqs_pkg::entry_type     next_in,
   input  cpqs_pkg::entry_type     wrap_in,
   input  cpqs_pkg::entry_type     load_in,
   output cpqs_pkg::entry_type     entry_out
);
   import cpqs_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A load has priority; otherwise the cell moves one place towards the head.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_in;
      end else if (ctl.shift) begin
         entry_in = ctl.take_wrap ? wrap_in : next_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

/* hdl/circular_priority_queue_scan.sv */
// Top level of the circular priority queue built as a chain of storage cells.
//
//  Port group   Direction  Handshake             Word
//  req_*        in         req_valid/req_ready   op, item value, item priority
//  rsp_*        out        rsp_valid/rsp_ready   status, value, occupancy
//  csr_*        in         csr_write_enable      queue capacity (clears the queue)
//
// An enqueue or an empty dequeue goes from acceptance to ST_DONE, which loads
// the response register. A dequeue of a non-empty queue rotates the chain once
// past the comparator at cell zero to find the winner, then once more to drop
// it. Entries are kept oldest first from cell zero. The response sits in
// an output register, so a new request is taken while it waits. Reset empties
// the queue and sets the capacity to the smaller of 16 and DEPTH.
module circular_priority_queue_scan #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [cpqs_pkg::VALUE_W-1:0] req_item_value,
   input  logic signed [cpqs_pkg::PRIO_W-1:0]  req_item_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cpqs_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [cpqs_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [cpqs_pkg::CAP_W-1:0]          rsp_occupancy,
   input  logic                                csr_write_enable,
   input  logic [cpqs_pkg::CAP_W-1:0]          csr_write_data
);
   import cpqs_pkg::*;

   localparam int IW        = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DROP, ST_DONE} state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cap_ff, cap_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic [IW-1:0]             step_ff, step_in;
   logic [IW-1:0]             best_idx_ff, best_idx_in;
   logic signed [PRIO_W-1:0]  best_prio_ff, best_prio_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CAP_W-1:0]          rsp_occ_ff, rsp_occ_in;

   logic                      accept;
   logic                      shift;
   logic                      wrap_en;
   logic                      enq_load;
   logic                      last_step;
   logic [CMP_W-1:0]          wdata_wide;
   logic [CNT_W-1:0]          cap_clamped;
   entry_type                 load_entry;
   entry_type                 cell_q [DEPTH];
   cell_ctl_type              cell_ctl [DEPTH];

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign load_entry = '{value: req_item_value, prio: req_item_priority};
   assign last_step  = ((CNT_W'(step_ff) + CNT_W'(1)) == count_ff);

   // Capacity write: zero acts as one, anything above the built depth as DEPTH.
   assign wdata_wide = CMP_W'(csr_write_data);
   always_comb begin
      if (wdata_wide == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (wdata_wide > CMP_W'(DEPTH)) begin
         cap_clamped = CNT_W'(DEPTH);
      end else begin
         cap_clamped = CNT_W'(wdata_wide);
      end
   end

   // The chain of cells; the last cell is fed from cell zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_ctl[i].shift     = shift;
      assign cell_ctl[i].take_wrap = wrap_en && (CNT_W'(i) == (len_ff - CNT_W'(1)));
      assign cell_ctl[i].load      = enq_load && (CNT_W'(i) == count_ff);

      cpqs_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .next_in   (cell_q[(i + 1) % DEPTH]),
         .wrap_in   (cell_q[0]),
         .load_in   (load_entry),
         .entry_out (cell_q[i])
      );
   end

   // Sequencer: scan pass finds the winner, drop pass removes it.
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      res_value_in  = res_value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_occ_in    = rsp_occ_ff;
      shift         = 1'b0;
      wrap_en       = 1'b0;
      enq_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               cap_in   = cap_clamped;
               count_in = '0;
            end else if (accept) begin
               res_value_in = '0;
               status_in    = STATUS_OK;
               if (req_op == OP_ENQUEUE) begin
                  if (count_ff >= cap_ff) begin
                     status_in = STATUS_FULL;
                  end else begin
                     enq_load = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  step_in  = '0;
                  len_in   = count_ff;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            shift   = 1'b1;
            wrap_en = 1'b1;
            // Strictly greater only, so the oldest of equal priorities is kept.
            if ((step_ff == '0) || (cell_q[0].prio > best_prio_ff)) begin
               best_prio_in = cell_q[0].prio;
               res_value_in = cell_q[0].value;
               best_idx_in  = step_ff;
            end
            if (last_step) begin
               step_in  = '0;
               state_in = ST_DROP;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         ST_DROP: begin
            shift = 1'b1;
            // The winner leaves cell zero without wrapping; the ring shrinks by one.
            if (step_ff == best_idx_ff) begin
               len_in = len_ff - CNT_W'(1);
            end else begin
               wrap_en = 1'b1;
            end
            if (last_step) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = res_value_ff;
               rsp_occ_in    = CAP_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CNT_W'(CAP_RESET);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff        <= len_in;
      step_ff       <= step_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      res_value_ff  <= res_value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule
